@@ src/qse_pkg.sv @@
`timescale 1ns / 1ps

package qse_pkg;

  // store geometry
  localparam int MAX_COUNT   = 64;
  localparam int IDX_W       = $clog2(MAX_COUNT);
  localparam int CNT_W       = $clog2(MAX_COUNT + 1);
  localparam int STACK_SLOTS = 64;
  localparam int SP_W        = $clog2(STACK_SLOTS);
  localparam int DEPTH_W     = $clog2(STACK_SLOTS + 1);
  localparam int DATA_W      = 32;
  localparam int POS_W       = 6;

  // one pending subrange on the range stack
  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  // element store access, one write and one read
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } elem_req_t;

  // range stack access, one write and one read
  typedef struct packed {
    logic            we;
    logic [SP_W-1:0] waddr;
    range_t          wdata;
    logic [SP_W-1:0] raddr;
  } stk_req_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_PIV,
    ST_PIV,
    ST_RD_I,
    ST_CMP,
    ST_SWPA,
    ST_SWPB,
    ST_FINA,
    ST_FINB,
    ST_PUSH,
    ST_POP,
    ST_POPW,
    ST_EMIT
  } state_t;

endpackage

@@ src/qse_elem_store.sv @@
`timescale 1ns / 1ps

module qse_elem_store
  import qse_pkg::*;
(
  input  logic              clk,
  input  elem_req_t         req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [MAX_COUNT];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ src/qse_range_stack.sv @@
`timescale 1ns / 1ps

module qse_range_stack
  import qse_pkg::*;
(
  input  logic     clk,
  input  stk_req_t req,
  output range_t   rdata
);

  range_t mem [STACK_SLOTS];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ src/qse_ctrl.sv @@
`timescale 1ns / 1ps

module qse_ctrl
  import qse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_last,
  output elem_req_t         elem_req,
  input  logic [DATA_W-1:0] elem_rdata,
  output stk_req_t          stk_req,
  input  range_t            stk_rdata,
  output logic              out_valid,
  output logic [POS_W-1:0]  out_position,
  output logic              out_final_res,
  output logic              out_dropped
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [IDX_W-1:0]    lo_r, lo_nxt;
  logic [IDX_W-1:0]    hi_r, hi_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [IDX_W-1:0]    ind_r, ind_nxt;
  logic [DATA_W-1:0]   pivot_r, pivot_nxt;
  logic [DATA_W-1:0]   tmp_r, tmp_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  range_t              push0_r, push0_nxt;
  range_t              push1_r, push1_nxt;
  logic [1:0]          npush_r, npush_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic                oval_r, oval_nxt;
  logic [POS_W-1:0]    opos_r, opos_nxt;
  logic                ofin_r, ofin_nxt;
  logic                odrop_r, odrop_nxt;

  logic [CNT_W-1:0]    n_load;
  logic [CNT_W-1:0]    k_inc;
  logic [IDX_W-1:0]    i_inc;
  logic                is_less;
  logic                has_left, has_right;
  logic [IDX_W-1:0]    left_len, right_len;
  range_t              left_rng, right_rng;

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = oval_r;
  assign out_position  = opos_r;
  assign out_final_res = ofin_r;
  assign out_dropped   = odrop_r;

  // helpers for compare and split
  assign is_less   = $signed(elem_rdata) < $signed(pivot_r);
  assign i_inc     = i_r + 1'b1;
  assign k_inc     = k_r + 1'b1;
  assign has_left  = {1'b0, ind_r} >= ({1'b0, lo_r} + 2'd2);
  assign has_right = {1'b0, hi_r} >= ({1'b0, ind_r} + 2'd2);
  assign left_len  = ind_r - lo_r;
  assign right_len = hi_r - ind_r;
  assign left_rng  = '{lo: lo_r, hi: ind_r - 1'b1};
  assign right_rng = '{lo: ind_r + 1'b1, hi: hi_r};

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      depth_r <= '0;
      npush_r <= '0;
      k_r     <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      depth_r <= depth_nxt;
      npush_r <= npush_nxt;
      k_r     <= k_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    ind_r   <= ind_nxt;
    pivot_r <= pivot_nxt;
    tmp_r   <= tmp_nxt;
    push0_r <= push0_nxt;
    push1_r <= push1_nxt;
    opos_r  <= opos_nxt;
    ofin_r  <= ofin_nxt;
    odrop_r <= odrop_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    ind_nxt   = ind_r;
    pivot_nxt = pivot_r;
    tmp_nxt   = tmp_r;
    depth_nxt = depth_r;
    push0_nxt = push0_r;
    push1_nxt = push1_r;
    npush_nxt = npush_r;
    k_nxt     = k_r;
    oval_nxt  = 1'b0;
    opos_nxt  = opos_r;
    ofin_nxt  = ofin_r;
    odrop_nxt = odrop_r;
    n_load    = count_r;
    elem_req  = '{we: 1'b0, waddr: '0, wdata: in_value, raddr: '0};
    stk_req   = '{we: 1'b0, waddr: depth_r[SP_W-1:0], wdata: push0_r, raddr: '0};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // append item unless the store is full
          if (count_r < CNT_W'(MAX_COUNT)) begin
            elem_req.we    = 1'b1;
            elem_req.waddr = count_r[IDX_W-1:0];
            n_load         = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          count_nxt = n_load;
          if (in_last) begin
            k_nxt = '0;
            if (n_load >= CNT_W'(2)) begin
              lo_nxt    = '0;
              hi_nxt    = IDX_W'(n_load - 1'b1);
              depth_nxt = '0;
              state_nxt = ST_LOAD_PIV;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
        end
      end

      ST_LOAD_PIV: begin
        elem_req.raddr = hi_r;
        i_nxt          = lo_r;
        ind_nxt        = lo_r;
        state_nxt      = ST_PIV;
      end

      ST_PIV: begin
        pivot_nxt = elem_rdata;
        state_nxt = ST_RD_I;
      end

      ST_RD_I: begin
        if (i_r == hi_r) begin
          elem_req.raddr = ind_r;
          state_nxt      = ST_FINA;
        end else begin
          elem_req.raddr = i_r;
          state_nxt      = ST_CMP;
        end
      end

      ST_CMP: begin
        if (is_less) begin
          tmp_nxt        = elem_rdata;
          elem_req.raddr = ind_r;
          state_nxt      = ST_SWPA;
        end else begin
          // stream the next element while no swap is pending
          i_nxt = i_inc;
          if (i_inc != hi_r) begin
            elem_req.raddr = i_inc;
          end else begin
            state_nxt = ST_RD_I;
          end
        end
      end

      ST_SWPA: begin
        elem_req.we    = 1'b1;
        elem_req.waddr = i_r;
        elem_req.wdata = elem_rdata;
        state_nxt      = ST_SWPB;
      end

      ST_SWPB: begin
        elem_req.we    = 1'b1;
        elem_req.waddr = ind_r;
        elem_req.wdata = tmp_r;
        ind_nxt        = ind_r + 1'b1;
        i_nxt          = i_inc;
        state_nxt      = ST_RD_I;
      end

      ST_FINA: begin
        elem_req.we    = 1'b1;
        elem_req.waddr = hi_r;
        elem_req.wdata = elem_rdata;
        state_nxt      = ST_FINB;
      end

      ST_FINB: begin
        elem_req.we    = 1'b1;
        elem_req.waddr = ind_r;
        elem_req.wdata = pivot_r;
        // larger side first so the smaller one pops next
        if (has_left && has_right) begin
          npush_nxt = 2'd2;
          if (left_len > right_len) begin
            push0_nxt = left_rng;
            push1_nxt = right_rng;
          end else begin
            push0_nxt = right_rng;
            push1_nxt = left_rng;
          end
        end else if (has_left) begin
          npush_nxt = 2'd1;
          push0_nxt = left_rng;
        end else if (has_right) begin
          npush_nxt = 2'd1;
          push0_nxt = right_rng;
        end else begin
          npush_nxt = 2'd0;
        end
        state_nxt = ST_PUSH;
      end

      ST_PUSH: begin
        if (npush_r != 2'd0) begin
          if (depth_r < DEPTH_W'(STACK_SLOTS)) begin
            stk_req.we = 1'b1;
            depth_nxt  = depth_r + 1'b1;
          end
          push0_nxt = push1_r;
          npush_nxt = npush_r - 1'b1;
          if (npush_r == 2'd1) begin
            state_nxt = ST_POP;
          end
        end else begin
          state_nxt = ST_POP;
        end
      end

      ST_POP: begin
        if (depth_r == '0) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          stk_req.raddr = SP_W'(depth_r - 1'b1);
          depth_nxt     = depth_r - 1'b1;
          state_nxt     = ST_POPW;
        end
      end

      ST_POPW: begin
        lo_nxt = stk_rdata.lo;
        hi_nxt = stk_rdata.hi;
        if (stk_rdata.lo < stk_rdata.hi) begin
          state_nxt = ST_LOAD_PIV;
        end else begin
          state_nxt = ST_POP;
        end
      end

      ST_EMIT: begin
        // one sorted element per cycle, data appears with the strobe
        elem_req.raddr = k_r[IDX_W-1:0];
        oval_nxt       = 1'b1;
        opos_nxt       = POS_W'(k_r);
        ofin_nxt       = (k_inc == count_r);
        odrop_nxt      = ovf_r;
        k_nxt          = k_inc;
        if (k_inc == count_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/quicksort_engine.sv @@
`timescale 1ns / 1ps

// Sorting engine for sets of up to 64 signed 32-bit values. Items are taken
// one per cycle while busy is low; each appends its value to the element
// store, and an item with in_last high closes the set (items beyond 64 are
// discarded and reported through out_dropped). The set is then sorted in
// place by quicksort with Lomuto partitioning, last element as pivot, with
// pending subranges kept on a range stack in a second memory. Each range is
// opened by reading its pivot; a scanned element that stays put lets the
// next one be read at once, while an element moved below the pivot takes a
// read of the swap slot, two writes and a fresh read. The pivot is then
// placed, the subranges are pushed and the next range is popped. A set that
// arrives in strictly ascending order moves every scanned element. Results
// then leave at one per cycle on out_valid, positions 0 to n-1 in ascending
// order, the last one flagged by out_final_res. The receiver cannot stall the
// outputs; busy stays high until the final result has been issued, and the
// next set may start in the cycle that result is shown.
module quicksort_engine
  import qse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic [POS_W-1:0]         out_position,
  output logic                     out_final_res,
  output logic                     out_dropped
);

  elem_req_t         elem_req;
  logic [DATA_W-1:0] elem_rdata;
  stk_req_t          stk_req;
  range_t            stk_rdata;

  // sequencer
  qse_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_last       (in_last),
    .elem_req      (elem_req),
    .elem_rdata    (elem_rdata),
    .stk_req       (stk_req),
    .stk_rdata     (stk_rdata),
    .out_valid     (out_valid),
    .out_position  (out_position),
    .out_final_res (out_final_res),
    .out_dropped   (out_dropped)
  );

  // element store
  qse_elem_store u_elem (
    .clk   (clk),
    .req   (elem_req),
    .rdata (elem_rdata)
  );

  // range stack
  qse_range_stack u_stack (
    .clk   (clk),
    .req   (stk_req),
    .rdata (stk_rdata)
  );

  // read data of the store doubles as the output value
  assign out_sorted_value = elem_rdata;

endmodule

@@ src/qse_checker.sv @@
`timescale 1ns / 1ps

module qse_checker
  import qse_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic signed [DATA_W-1:0] in_value,
  input logic                     in_last,
  input logic                     out_valid,
  input logic signed [DATA_W-1:0] out_sorted_value,
  input logic [POS_W-1:0]         out_position,
  input logic                     out_final_res,
  input logic                     out_dropped
);

  // the engine stays idle after taking a non-closing item
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last |=> !busy)
    else $error("engine went busy on a non-closing item");

  // results other than the final one are only issued while the engine works on a set
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |-> busy)
    else $error("result shown while idle");

  // results come back to back with rising positions
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |=>
      out_valid && (out_position == $past(out_position) + 1'b1))
    else $error("result stream broken or position skipped");

  // results leave in ascending order
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |=> out_sorted_value >= $past(out_sorted_value))
    else $error("result stream not ascending");

  // nothing follows the final result of a set
  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |=> !out_valid)
    else $error("result after the final one");

endmodule

bind quicksort_engine qse_checker u_qse_checker (.*);
